// ===== hdl/ddgo_pkg.sv =====
package ddgo_pkg;

	localparam int DIV_BITS = 52;
	localparam int CNT_W    = 6;
	localparam int IN_W     = 104;
	localparam int OUT_W    = 224;

	localparam logic [1:0] OP_STEP       = 2'd0;
	localparam logic [1:0] OP_RESET_POSE = 2'd1;
	localparam logic [1:0] OP_RESET_DIST = 2'd2;

	localparam logic signed [32:0] PI_Q      = 33'sd843314857;
	localparam logic signed [32:0] TWO_PI_Q  = 33'sd1686629713;
	localparam logic signed [32:0] HALF_PI_Q = 33'sd421657428;
	localparam logic signed [29:0] DPSI_MUL  = 30'sd314410567;
	localparam logic signed [21:0] OMEGA_MUL = 22'sd1171271;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [19:0] US_PER_S = 20'd1000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DS,
		ST_PREP,
		ST_ITER,
		ST_POS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             mul;
		logic             sum;
		logic             ds;
		logic             prep;
		logic             iter;
		logic             pos;
		logic             commit;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic integ;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [27:0] atan_lut(input logic [4:0] i);
		logic [27:0] r;
		case (i)
			5'd0:  r = 28'd210828714;
			5'd1:  r = 28'd124459457;
			5'd2:  r = 28'd65760959;
			5'd3:  r = 28'd33381289;
			5'd4:  r = 28'd16755421;
			5'd5:  r = 28'd8385878;
			5'd6:  r = 28'd4193962;
			5'd7:  r = 28'd2097109;
			5'd8:  r = 28'd1048570;
			5'd9:  r = 28'd524287;
			5'd10: r = 28'd262143;
			5'd11: r = 28'd131071;
			5'd12: r = 28'd65535;
			5'd13: r = 28'd32767;
			5'd14: r = 28'd16383;
			5'd15: r = 28'd8191;
			5'd16: r = 28'd4095;
			5'd17: r = 28'd2047;
			5'd18: r = 28'd1023;
			5'd19: r = 28'd511;
			5'd20: r = 28'd255;
			5'd21: r = 28'd127;
			5'd22: r = 28'd63;
			5'd23: r = 28'd31;
			5'd24: r = 28'd15;
			5'd25: r = 28'd7;
			5'd26: r = 28'd3;
			5'd27: r = 28'd1;
			default: r = 28'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ddgo_ctrl.sv =====
module ddgo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  ddgo_pkg::sts_t  sts,
	output logic            in_ready,
	output logic            out_valid,
	output ddgo_pkg::cmd_t  cmd
);

	ddgo_pkg::state_t state_q, state_d;
	logic [ddgo_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic can_commit;

	assign can_commit = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ddgo_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.integ ? ddgo_pkg::ST_MUL : ddgo_pkg::ST_DONE;
				end
			end
			ddgo_pkg::ST_MUL:  state_d = ddgo_pkg::ST_SUM;
			ddgo_pkg::ST_SUM:  state_d = ddgo_pkg::ST_DS;
			ddgo_pkg::ST_DS:   state_d = ddgo_pkg::ST_PREP;
			ddgo_pkg::ST_PREP: state_d = ddgo_pkg::ST_ITER;
			ddgo_pkg::ST_ITER: begin
				if (cnt_q == ddgo_pkg::CNT_W'(ddgo_pkg::DIV_BITS - 1)) begin
					state_d = ddgo_pkg::ST_POS;
				end
			end
			ddgo_pkg::ST_POS:  state_d = ddgo_pkg::ST_DONE;
			ddgo_pkg::ST_DONE: begin
				if (can_commit) begin
					state_d = ddgo_pkg::ST_IDLE;
				end
			end
			default: state_d = ddgo_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ddgo_pkg::ST_IDLE);
		cmd.load   = in_valid && (state_q == ddgo_pkg::ST_IDLE);
		cmd.mul    = (state_q == ddgo_pkg::ST_MUL);
		cmd.sum    = (state_q == ddgo_pkg::ST_SUM);
		cmd.ds     = (state_q == ddgo_pkg::ST_DS);
		cmd.prep   = (state_q == ddgo_pkg::ST_PREP);
		cmd.iter   = (state_q == ddgo_pkg::ST_ITER);
		cmd.pos    = (state_q == ddgo_pkg::ST_POS);
		cmd.commit = (state_q == ddgo_pkg::ST_DONE) && can_commit;
		cmd.cnt    = cnt_q;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddgo_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.iter) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/ddgo_dp.sv =====
module ddgo_dp #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ddgo_pkg::cmd_t              cmd,
	input  logic [1:0]                  op,
	input  logic [31:0]                 left_count,
	input  logic [31:0]                 right_count,
	input  logic signed [16:0]          yaw_rate,
	input  logic [15:0]                 step_time,
	input  logic [23:0]                 mm_per_tick,
	output ddgo_pkg::sts_t              sts,
	output logic [ddgo_pkg::OUT_W-1:0]  out_data,
	output logic                        out_skipped
);

	// latched transaction
	logic [1:0]         op_q;
	logic [31:0]        lin_q, rin_q;
	logic signed [16:0] yaw_q;
	logic [15:0]        dt_q;

	// architectural state
	logic [31:0]        last_l_q, last_r_q;
	logic signed [31:0] px_q, py_q, ang_q, vel_q, om_q, lt_q, rt_q;

	logic signed [56:0] lprod_s1, rprod_s1;
	logic signed [33:0] yawdt_s1;
	logic signed [38:0] omprod_s1;

	logic signed [48:0] lm_s2, rm_s2;
	logic signed [63:0] dpsiprod_s2;
	logic signed [31:0] om_s2;

	logic signed [33:0] ds_s3;
	logic signed [31:0] dpsi_s3;
	logic signed [32:0] ang_s3;
	logic signed [31:0] lt_s3, rt_s3;

	logic                        flip_q, neg_q;
	logic [16:0]                 rem_q;
	logic [ddgo_pkg::DIV_BITS-1:0] quo_q;
	logic signed [33:0]          cx_q, cy_q;
	logic signed [32:0]          cz_q;

	logic signed [67:0] pxprod_s5, pyprod_s5;
	logic signed [31:0] vel_s5;

	logic [31:0]        out_x_q, out_y_q, out_h_q, out_v_q, out_o_q, out_l_q, out_r_q;
	logic               out_skip_q;

	assign sts.integ = (op == ddgo_pkg::OP_STEP) && (step_time != 16'd0);

	// MUL
	logic signed [31:0] dl, dr;
	assign dl = $signed(lin_q - last_l_q);
	assign dr = $signed(rin_q - last_r_q);

	// SUM
	logic signed [56:0] lr_l, lr_r;
	logic signed [38:0] om_rnd;
	assign lr_l   = (lprod_s1 + 57'sd128) >>> 8;
	assign lr_r   = (rprod_s1 + 57'sd128) >>> 8;
	assign om_rnd = (omprod_s1 + 39'sd32768) >>> 16;

	// DS
	logic signed [49:0] lsum, dsr;
	logic signed [63:0] dpsi_rnd;
	logic signed [32:0] ang_sum, ang_wrap;
	assign lsum     = 50'(lm_s2) + 50'(rm_s2);
	assign dsr      = lsum >>> 1;
	assign dpsi_rnd = (dpsiprod_s2 + 64'sd2147483648) >>> 32;
	assign ang_sum  = 33'(ang_q) + 33'(signed'(dpsi_rnd[31:0]));
	always_comb begin
		if (ang_sum > ddgo_pkg::PI_Q) begin
			ang_wrap = ang_sum - ddgo_pkg::TWO_PI_Q;
		end else if (ang_sum < -ddgo_pkg::PI_Q) begin
			ang_wrap = ang_sum + ddgo_pkg::TWO_PI_Q;
		end else begin
			ang_wrap = ang_sum;
		end
	end

	// PREP
	logic signed [32:0] mid, mid_fold;
	logic               mid_flip;
	logic [32:0]        ds_abs;
	assign mid = ang_s3 - 33'(dpsi_s3 >>> 1);
	always_comb begin
		mid_flip = 1'b0;
		mid_fold = mid;
		if (mid > ddgo_pkg::HALF_PI_Q) begin
			mid_fold = mid - ddgo_pkg::PI_Q;
			mid_flip = 1'b1;
		end else if (mid < -ddgo_pkg::HALF_PI_Q) begin
			mid_fold = mid + ddgo_pkg::PI_Q;
			mid_flip = 1'b1;
		end
	end
	assign ds_abs = ds_s3[33] ? 33'(-ds_s3) : 33'(ds_s3);

	// ITER
	logic [16:0]        rem_sh;
	logic               cstep;
	logic [4:0]         sh;
	logic signed [33:0] xs, ys;
	logic signed [32:0] at;
	assign rem_sh = {rem_q[15:0], quo_q[ddgo_pkg::DIV_BITS-1]};
	assign cstep  = cmd.iter && ({1'b0, cmd.cnt} < 7'(CORDIC_STEPS));
	assign sh     = cmd.cnt[4:0];
	assign xs     = cx_q >>> sh;
	assign ys     = cy_q >>> sh;
	assign at     = $signed({5'd0, ddgo_pkg::atan_lut(sh)});

	// POS
	logic signed [33:0] cosv, sinv;
	assign cosv = flip_q ? -cx_q : cx_q;
	assign sinv = flip_q ? -cy_q : cy_q;

	// DONE
	logic signed [67:0] pxr, pyr;
	logic signed [31:0] px_new, py_new;
	assign pxr    = (pxprod_s5 + 68'sd536870912) >>> 30;
	assign pyr    = (pyprod_s5 + 68'sd536870912) >>> 30;
	assign px_new = ddgo_pkg::sat32(64'(px_q) + 64'(signed'(pxr[35:0])));
	assign py_new = ddgo_pkg::sat32(64'(py_q) + 64'(signed'(pyr[35:0])));

	logic [31:0]        nl, nr;
	logic signed [31:0] nx, ny, na, nv, no, nlt, nrt;
	logic               nskip;
	always_comb begin
		nl = last_l_q; nr = last_r_q;
		nx = px_q; ny = py_q; na = ang_q; nv = vel_q; no = om_q;
		nlt = lt_q; nrt = rt_q;
		nskip = 1'b0;
		unique case (op_q)
			ddgo_pkg::OP_STEP: begin
				if (dt_q == 16'd0) begin
					nskip = 1'b1;
				end else begin
					nl = lin_q; nr = rin_q;
					nx = px_new; ny = py_new; na = ang_s3[31:0];
					nv = vel_s5; no = om_s2; nlt = lt_s3; nrt = rt_s3;
				end
			end
			ddgo_pkg::OP_RESET_POSE: begin
				nl = lin_q; nr = rin_q;
				nx = '0; ny = '0; na = '0; nv = '0; no = '0; nlt = '0; nrt = '0;
			end
			ddgo_pkg::OP_RESET_DIST: begin
				nl = lin_q; nr = rin_q; nlt = '0; nrt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_l_q <= '0; last_r_q <= '0;
			px_q <= '0; py_q <= '0; ang_q <= '0; vel_q <= '0; om_q <= '0;
			lt_q <= '0; rt_q <= '0;
		end else if (cmd.commit) begin
			last_l_q <= nl; last_r_q <= nr;
			px_q <= nx; py_q <= ny; ang_q <= na; vel_q <= nv; om_q <= no;
			lt_q <= nlt; rt_q <= nrt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; lin_q <= left_count; rin_q <= right_count;
			yaw_q <= yaw_rate; dt_q <= step_time;
		end
		if (cmd.mul) begin
			lprod_s1  <= dl * $signed({1'b0, mm_per_tick});
			rprod_s1  <= dr * $signed({1'b0, mm_per_tick});
			yawdt_s1  <= yaw_q * $signed({1'b0, dt_q});
			omprod_s1 <= yaw_q * ddgo_pkg::OMEGA_MUL;
		end
		if (cmd.sum) begin
			lm_s2       <= lr_l[48:0];
			rm_s2       <= lr_r[48:0];
			dpsiprod_s2 <= yawdt_s1 * ddgo_pkg::DPSI_MUL;
			om_s2       <= om_rnd[31:0];
		end
		if (cmd.ds) begin
			if (dsr > 50'sd4294967296) begin
				ds_s3 <= 34'sd4294967296;
			end else if (dsr < -50'sd4294967296) begin
				ds_s3 <= -34'sd4294967296;
			end else begin
				ds_s3 <= dsr[33:0];
			end
			dpsi_s3 <= dpsi_rnd[31:0];
			ang_s3  <= ang_wrap;
			lt_s3   <= ddgo_pkg::sat32(64'(lt_q) + 64'(lm_s2));
			rt_s3   <= ddgo_pkg::sat32(64'(rt_q) + 64'(rm_s2));
		end
		if (cmd.prep) begin
			flip_q <= mid_flip;
			cx_q   <= ddgo_pkg::CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= mid_fold;
			neg_q  <= ds_s3[33];
			rem_q  <= '0;
			quo_q  <= ddgo_pkg::DIV_BITS'({19'd0, ds_abs} * {32'd0, ddgo_pkg::US_PER_S});
		end
		if (cmd.iter) begin
			if (rem_sh >= {1'b0, dt_q}) begin
				rem_q <= rem_sh - {1'b0, dt_q};
				quo_q <= {quo_q[ddgo_pkg::DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[ddgo_pkg::DIV_BITS-2:0], 1'b0};
			end
		end
		if (cstep) begin
			if (!cz_q[32]) begin
				cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
			end
		end
		if (cmd.pos) begin
			pxprod_s5 <= ds_s3 * cosv;
			pyprod_s5 <= ds_s3 * sinv;
			if (!neg_q) begin
				vel_s5 <= (quo_q > 52'd2147483647) ? 32'sh7fffffff : signed'(quo_q[31:0]);
			end else begin
				vel_s5 <= (quo_q > 52'd2147483648) ? 32'sh80000000 : signed'(-quo_q[31:0]);
			end
		end
		if (cmd.commit) begin
			out_x_q <= nx; out_y_q <= ny; out_h_q <= na; out_v_q <= nv; out_o_q <= no;
			out_l_q <= nlt; out_r_q <= nrt; out_skip_q <= nskip;
		end
	end

	assign out_data = {1'b0, out_r_q, out_l_q, out_o_q, out_v_q, out_h_q[30:0], out_y_q,
		out_x_q};
	assign out_skipped = out_skip_q;

endmodule

// ===== hdl/diff_drive_gyro_odometry.sv =====
// Dead-reckoning pose tracker. One transaction in, one transaction out. An integrate
// step runs MUL, SUM, DS, PREP, ITER, POS and DONE; ITER runs the radix-2 speed divider
// (52 iterations) beside the CORDIC. Reset ops, unknown ops and zero-time steps skip to
// DONE. One item is processed at a time; the result sits in an output register so the
// next item may be accepted before it is taken. The user is to write the mm_per_tick
// register through cfg_valid/cfg_ready while idle; the block does not enforce it.
module diff_drive_gyro_odometry #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [23:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // left_count, right_count, yaw_rate, step_time, pad
	input  logic [1:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_pos, y_pos, heading, speed, turn_rate, left_distance, right_distance, pad
	output logic [223:0] m_tdata,
	output logic [0:0]   m_tuser   // skipped
);

	ddgo_pkg::cmd_t cmd;
	ddgo_pkg::sts_t sts;
	logic [23:0]    mm_q;
	logic           skip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q <= 24'd65536;
		end else if (cfg_valid) begin
			mm_q <= cfg_data;
		end
	end

	ddgo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	ddgo_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (s_tuser),
		.left_count  (s_tdata[31:0]),
		.right_count (s_tdata[63:32]),
		.yaw_rate    (s_tdata[80:64]),
		.step_time   (s_tdata[96:81]),
		.mm_per_tick (mm_q),
		.sts         (sts),
		.out_data    (m_tdata),
		.out_skipped (skip)
	);

	assign m_tuser = skip;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second transaction while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a finished transaction");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[94:64]) <= 31'sd843314857 &&
			$signed(m_tdata[94:64]) >= -31'sd843314857))
		else $error("heading outside [-pi, pi]");
`endif

endmodule

// ===== dv/diff_drive_gyro_odometry_tb.sv =====
module diff_drive_gyro_odometry_tb;

	typedef struct packed {
		logic        skipped;
		logic [31:0] right_distance;
		logic [31:0] left_distance;
		logic [31:0] turn_rate;
		logic [31:0] speed;
		logic [30:0] heading;
		logic [31:0] y_pos;
		logic [31:0] x_pos;
	} pose_t;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [23:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [223:0] m_tdata;
	logic [0:0]   m_tuser;

	pose_t pose_q[$];
	int    errors;
	int    stall_mode;

	logic [23:0] scale;
	logic [31:0] prev_left, prev_right;
	logic signed [31:0] px, py, ang, vel, om, ltrav, rtrav;

	localparam longint ATAN_TAB[32] = '{
		210828714, 124459457, 65760959, 33381289, 16755421, 8385878, 4193962,
		2097109, 1048570, 524287, 262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0, 0, 0};

	diff_drive_gyro_odometry dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic rotate(input longint a, output longint c, output longint s);
		longint x, y, z, xs, ys;
		bit flip;
		flip = 0;
		x = 652032874;
		y = 0;
		if (a > 421657428) begin
			a -= 843314857;
			flip = 1;
		end else if (a < -421657428) begin
			a += 843314857;
			flip = 1;
		end
		z = a;
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end else begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input logic [1:0] op, input logic [31:0] lc,
			input logic [31:0] rc, input logic [16:0] yaw_raw, input logic [15:0] dt_raw);
		pose_t p;
		longint dl, dr, yaw, dt, lm, rm, ds, dpsi, a, c, s;
		logic [31:0] tmp;
		p = '0;
		if (op == ddgo_pkg::OP_STEP) begin
			if (dt_raw == 0) begin
				p.skipped = 1'b1;
			end else begin
				tmp = lc - prev_left;
				dl = $signed(tmp);
				tmp = rc - prev_right;
				dr = $signed(tmp);
				yaw = $signed(yaw_raw);
				dt = dt_raw;
				prev_left = lc;
				prev_right = rc;
				lm = floor_shift(dl * longint'(scale) + 128, 8);
				rm = floor_shift(dr * longint'(scale) + 128, 8);
				ltrav = clamp32(longint'(ltrav) + lm);
				rtrav = clamp32(longint'(rtrav) + rm);
				ds = floor_shift(lm + rm, 1);
				if (ds > 64'sd4294967296) ds = 64'sd4294967296;
				if (ds < -64'sd4294967296) ds = -64'sd4294967296;
				dpsi = floor_shift(yaw * dt * 314410567 + (64'sd1 << 31), 32);
				a = longint'(ang) + dpsi;
				while (a > 843314857) a -= 1686629713;
				while (a < -843314857) a += 1686629713;
				ang = a[31:0];
				om = 32'(floor_shift(yaw * 1171271 + 32768, 16));
				vel = clamp32((ds * 1000000) / dt);
				rotate(a - floor_shift(dpsi, 1), c, s);
				px = clamp32(longint'(px) + floor_shift(ds * c + (64'sd1 << 29), 30));
				py = clamp32(longint'(py) + floor_shift(ds * s + (64'sd1 << 29), 30));
			end
		end else if (op == ddgo_pkg::OP_RESET_POSE || op == ddgo_pkg::OP_RESET_DIST) begin
			if (op == ddgo_pkg::OP_RESET_POSE) begin
				px = 0; py = 0; ang = 0; vel = 0; om = 0;
			end
			prev_left = lc;
			prev_right = rc;
			ltrav = 0;
			rtrav = 0;
		end
		p.x_pos = px;
		p.y_pos = py;
		p.heading = ang[30:0];
		p.speed = vel;
		p.turn_rate = om;
		p.left_distance = ltrav;
		p.right_distance = rtrav;
		pose_q.push_back(p);
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 4);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [31:0] lc,
			input logic [31:0] rc, input logic [16:0] yaw, input logic [15:0] dt);
		int n;
		n = stall_mode ? gap_len() : 0;
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		predict_pose(op, lc, rc, yaw, dt);
		s_tvalid <= 1;
		s_tdata <= {7'b0, dt, yaw, rc, lc};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_scale(input logic [23:0] v);
		s_tvalid <= 0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		scale = v;
	endtask

	task automatic random_step(input int mode);
		logic [31:0] lc, rc;
		logic [15:0] dt;
		int k;
		k = $urandom_range(0, 99);
		case (mode)
			0: begin
				lc = prev_left + $urandom_range(0, 4000) - 2000;
				rc = prev_right + $urandom_range(0, 4000) - 2000;
			end
			default: begin
				lc = $urandom;
				rc = $urandom;
			end
		endcase
		dt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
		if (k < 85)
			send_item(ddgo_pkg::OP_STEP, lc, rc, 17'($urandom), dt);
		else if (k < 91)
			send_item(ddgo_pkg::OP_RESET_POSE, lc, rc, 17'($urandom), 16'($urandom));
		else if (k < 97)
			send_item(ddgo_pkg::OP_RESET_DIST, lc, rc, 17'($urandom), 16'($urandom));
		else
			send_item(OP_UNKNOWN, lc, rc, 17'($urandom), 16'($urandom));
	endtask

	task automatic test_directed();
		stall_mode = 0;
		send_item(ddgo_pkg::OP_STEP, 32'd100, 32'd100, 17'h0ffff, 16'd1000);
		send_item(ddgo_pkg::OP_STEP, 32'd300, 32'd50, 17'h10000, 16'd1);
		send_item(ddgo_pkg::OP_STEP, 32'd300, 32'd50, 17'd5, 16'd0);
		send_item(ddgo_pkg::OP_STEP, 32'h7fffffff, 32'h80000000, 17'h0ffff, 16'hffff);
		send_item(ddgo_pkg::OP_STEP, 32'h80000000, 32'h7fffffff, 17'h10000, 16'hffff);
		send_item(ddgo_pkg::OP_STEP, 32'hffffffff, 32'h0, 17'h0, 16'd7);
		send_item(OP_UNKNOWN, 32'hffffffff, 32'hffffffff, 17'h1ffff, 16'hffff);
		send_item(ddgo_pkg::OP_RESET_DIST, 32'h12345678, 32'hfedcba98, 17'd0, 16'd0);
		send_item(ddgo_pkg::OP_STEP, 32'h12345778, 32'hfedcbb98, 17'd640, 16'd50000);
		send_item(ddgo_pkg::OP_RESET_POSE, 32'hffffffff, 32'h0, 17'h1ffff, 16'hffff);
		for (int i = 0; i < 6; i++)
			send_item(ddgo_pkg::OP_STEP, prev_left + 500, prev_right + 700, 17'd60000,
				16'hffff);
	endtask

	task automatic test_scale_extremes();
		write_scale(24'hffffff);
		stall_mode = 1;
		send_item(ddgo_pkg::OP_STEP, prev_left + 32'h7fffffff, prev_right + 32'h80000000,
			17'd1, 16'd1);
		for (int i = 0; i < 40; i++) random_step(i % 2);
		write_scale(24'd0);
		for (int i = 0; i < 40; i++) random_step(i % 2);
	endtask

	task automatic test_random();
		logic [23:0] scales[4];
		scales = '{24'd65536, 24'd1, 24'd300000, 24'($urandom)};
		stall_mode = 1;
		foreach (scales[j]) begin
			write_scale(scales[j]);
			for (int i = 0; i < 200; i++) random_step(($urandom_range(0, 4) == 0) ? 1 : 0);
		end
	endtask

	initial begin
		logic [1:0] mode;
		int n;
		m_tready = 0;
		forever begin
			@(posedge clk);
			mode = 2'($urandom_range(0, 3));
			n = (stall_mode == 0 || mode != 0) ? 0 : gap_len();
			if (n == 0)
				m_tready <= 1;
			else begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
				m_tready <= 1;
			end
		end
	end

	initial begin
		pose_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[222:0]};
				if (pose_q.size() == 0) begin
					$display("%0t unexpected result %h", $time, got);
					errors++;
				end else begin
					want = pose_q.pop_front();
					if (got.x_pos !== want.x_pos)
						$display("%0t x_pos exp %h got %h", $time, want.x_pos, got.x_pos);
					if (got.y_pos !== want.y_pos)
						$display("%0t y_pos exp %h got %h", $time, want.y_pos, got.y_pos);
					if (got.heading !== want.heading)
						$display("%0t heading exp %h got %h", $time, want.heading,
							got.heading);
					if (got.speed !== want.speed)
						$display("%0t speed exp %h got %h", $time, want.speed, got.speed);
					if (got.turn_rate !== want.turn_rate)
						$display("%0t turn_rate exp %h got %h", $time, want.turn_rate,
							got.turn_rate);
					if (got.left_distance !== want.left_distance)
						$display("%0t left_distance exp %h got %h", $time,
							want.left_distance, got.left_distance);
					if (got.right_distance !== want.right_distance)
						$display("%0t right_distance exp %h got %h", $time,
							want.right_distance, got.right_distance);
					if (got.skipped !== want.skipped)
						$display("%0t skipped exp %b got %b", $time, want.skipped,
							got.skipped);
					if (got !== want || m_tdata[223] !== 1'b0) errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		errors = 0;
		stall_mode = 0;
		cfg_valid = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		scale = 24'd65536;
		prev_left = 0; prev_right = 0;
		px = 0; py = 0; ang = 0; vel = 0; om = 0; ltrav = 0; rtrav = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_scale_extremes();
		test_random();
		s_tvalid <= 0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
